@@ rtl/indexed_min_heap_queue_macros.svh @@
// assertion helpers for the heap queue
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH

// same-cycle implication
`define IMHQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/imq_pkg.sv @@
package imq_pkg;

	localparam int CAPACITY_DEF  = 256;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int ID_COUNT_DEF  = 256;

	localparam int ACT_W  = 3;
	localparam int ID_W   = 8;
	localparam int KEYF_W = 32;
	localparam int ST_W   = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_INS    = 3'd0,
		ACT_DELMIN = 3'd1,
		ACT_DELID  = 3'd2,
		ACT_CHKEY  = 3'd3,
		ACT_CLR    = 3'd4
	} act_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_NOTMEM  = 3'd3,
		ST_ALREADY = 3'd4
	} st_t;

	typedef struct packed {
		logic latch_in;
		logic decide;
		logic start_ins;
		logic start_clr;
		logic rd_root;
		logic take_min;
		logic take_pos;
		logic rd_last;
		logic take_last;
		logic up_rd;
		logic up_swap;
		logic dn_rd;
		logic dn_swap;
		logic place;
		logic load_res;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic             err;
		logic [ACT_W-1:0] act;
		logic             cnt_one;
		logic             last_hit;
		logic             p_zero;
		logic             l_ge;
		logic             up_less;
		logic             dn_less;
	} stat_t;

endpackage

@@ rtl/indexed_min_heap_queue.sv @@
// channel  direction  handshake            payload
// input    in         in_valid / in_stall  action, elem_id, key
// output   out        out_valid / out_stall status, out_id, out_key, min_valid,
//                                          min_id, min_key, count
//
// one item at a time, the time from input transfer to result set by the sift:
// each heap level walked takes a slot read, then a compare and move, up to 8 levels
// clear and error walk no levels, the longest case a key change walking down 8 levels
// reset clears count and member flags at once, heap slots need no clearing
// the next item is taken while a finished result waits under out_stall
module indexed_min_heap_queue import imq_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int ID_COUNT  = ID_COUNT_DEF,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ACT_W-1:0]  action,
	input  logic [ID_W-1:0]   elem_id,
	input  logic [KEYF_W-1:0] key,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ST_W-1:0]   status,
	output logic [ID_W-1:0]   out_id,
	output logic [KEYF_W-1:0] out_key,
	output logic              min_valid,
	output logic [ID_W-1:0]   min_id,
	output logic [KEYF_W-1:0] min_key,
	output logic [CNT_W-1:0]  count
);

	cmd_t  cmd;
	stat_t stat;

	imq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	imq_dpath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH),
		.ID_COUNT  (ID_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.action    (action),
		.elem_id   (elem_id),
		.key       (key),
		.cmd       (cmd),
		.stat      (stat),
		.status    (status),
		.out_id    (out_id),
		.out_key   (out_key),
		.min_valid (min_valid),
		.min_id    (min_id),
		.min_key   (min_key),
		.count     (count)
	);

endmodule

@@ rtl/imq_ctrl.sv @@
`include "indexed_min_heap_queue_macros.svh"

module imq_ctrl import imq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_DM_RD, S_POS_RD, S_LAST_RD, S_UP, S_UP_CMP,
		S_DOWN, S_DN_CMP, S_PLACE, S_ROOT, S_ROOT_RD, S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   moved_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (stat.err) begin
					state_d = S_ROOT;
				end else begin
					case (stat.act)
						ACT_INS: begin
							cmd.start_ins = 1'b1;
							state_d       = S_UP;
						end
						ACT_DELMIN: begin
							cmd.rd_root = 1'b1;
							state_d     = S_DM_RD;
						end
						ACT_DELID, ACT_CHKEY: begin
							state_d = S_POS_RD;
						end
						ACT_CLR: begin
							cmd.start_clr = 1'b1;
							state_d       = S_ROOT;
						end
						default: state_d = S_ROOT;
					endcase
				end
			end
			S_DM_RD: begin
				cmd.take_min = 1'b1;
				if (stat.cnt_one) begin
					state_d = S_ROOT;
				end else begin
					cmd.rd_last = 1'b1;
					state_d     = S_LAST_RD;
				end
			end
			S_POS_RD: begin
				cmd.take_pos = 1'b1;
				if (stat.act == ACT_CHKEY) begin
					state_d = S_UP;
				end else if (stat.last_hit) begin
					state_d = S_ROOT;
				end else begin
					cmd.rd_last = 1'b1;
					state_d     = S_LAST_RD;
				end
			end
			S_LAST_RD: begin
				cmd.take_last = 1'b1;
				state_d       = S_UP;
			end
			S_UP: begin
				if (stat.p_zero) begin
					state_d = moved_q ? S_PLACE : S_DOWN;
				end else begin
					cmd.up_rd = 1'b1;
					state_d   = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_less) begin
					cmd.up_swap = 1'b1;
					state_d     = S_UP;
				end else begin
					state_d = moved_q ? S_PLACE : S_DOWN;
				end
			end
			S_DOWN: begin
				if (stat.l_ge) begin
					state_d = S_PLACE;
				end else begin
					cmd.dn_rd = 1'b1;
					state_d   = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_less) begin
					cmd.dn_swap = 1'b1;
					state_d     = S_DOWN;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_ROOT;
			end
			S_ROOT: begin
				cmd.rd_root = 1'b1;
				state_d     = S_ROOT_RD;
			end
			S_ROOT_RD: begin
				cmd.load_res = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			moved_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.decide || cmd.take_pos || cmd.take_last) begin
				moved_q <= 1'b0;
			end else if (cmd.up_swap) begin
				moved_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`IMHQ_ASSERT_NEXT(a_accept_decide, in_valid && !in_stall, state_q == S_DECIDE, "accept did not start decode")
	`IMHQ_ASSERT_NEXT(a_fin_hold, state_q == S_FIN && out_valid_q && out_stall, state_q == S_FIN, "result overwritten while stalled")
	`IMHQ_ASSERT_NEXT(a_place_root, cmd.place, state_q == S_ROOT, "place not followed by root read")
	`IMHQ_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid_q || !out_stall, "output loaded while occupied")

endmodule

@@ rtl/imq_dpath.sv @@
module imq_dpath import imq_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int ID_COUNT  = ID_COUNT_DEF,
	localparam int POS_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1),
	localparam int IDX_W = $clog2(ID_COUNT),
	localparam int CMP_W = POS_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ACT_W-1:0]  action,
	input  logic [ID_W-1:0]   elem_id,
	input  logic [KEYF_W-1:0] key,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic [ST_W-1:0]   status,
	output logic [ID_W-1:0]   out_id,
	output logic [KEYF_W-1:0] out_key,
	output logic              min_valid,
	output logic [ID_W-1:0]   min_id,
	output logic [KEYF_W-1:0] min_key,
	output logic [CNT_W-1:0]  count
);

	logic [ID_W-1:0]      slot_id_mem [CAPACITY];
	logic [KEY_WIDTH-1:0] slot_key_mem [CAPACITY];
	logic [POS_W-1:0]     pos_mem [ID_COUNT];

	logic [ACT_W-1:0]     act_q;
	logic [ID_W-1:0]      id_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [ST_W-1:0]      st_q;
	logic [ID_W-1:0]      oid_q;
	logic [KEY_WIDTH-1:0] okey_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ID_COUNT-1:0]  member_q;
	logic [POS_W-1:0]     p_q;
	logic [ID_W-1:0]      e_id_q;
	logic [KEY_WIDTH-1:0] e_key_q;
	logic                 r_ok_q;
	logic                 res_valid_q;
	logic [ID_W-1:0]      res_id_q;
	logic [KEY_WIDTH-1:0] res_key_q;

	logic [ST_W-1:0]      status_q;
	logic [ID_W-1:0]      out_id_q;
	logic [KEYF_W-1:0]    out_key_q;
	logic                 min_valid_q;
	logic [ID_W-1:0]      min_id_q;
	logic [KEYF_W-1:0]    min_key_q;
	logic [CNT_W-1:0]     count_q;

	logic [ID_W-1:0]      ra_id, rb_id;
	logic [KEY_WIDTH-1:0] ra_key, rb_key;
	logic [POS_W-1:0]     rp;

	logic [IDX_W-1:0]     id_idx;
	logic                 id_ok, member_hit, full;
	logic [ST_W-1:0]      err_code;
	logic [CNT_W-1:0]     cnt_m1;
	logic [POS_W-1:0]     last_addr, parent;
	logic [CMP_W-1:0]     l_ext, r_ext, cnt_ext;
	logic                 l_ge, r_ok;
	logic [POS_W-1:0]     addr_a, addr_b;
	logic                 pick_r;
	logic [ID_W-1:0]      best_id;
	logic [KEY_WIDTH-1:0] best_key;
	logic [POS_W-1:0]     best_idx;

	logic                 slot_we;
	logic [POS_W-1:0]     slot_waddr;
	logic [ID_W-1:0]      slot_wid;
	logic [KEY_WIDTH-1:0] slot_wkey;

	assign id_idx     = IDX_W'(id_q);
	assign id_ok      = (17'(id_q) < 17'(ID_COUNT));
	assign member_hit = id_ok && member_q[id_idx];
	assign full       = (cnt_q >= CNT_W'(CAPACITY));

	always_comb begin
		err_code = ST_OK;
		case (act_q)
			ACT_INS: begin
				if (!id_ok) begin
					err_code = ST_NOTMEM;
				end else if (member_hit) begin
					err_code = ST_ALREADY;
				end else if (full) begin
					err_code = ST_FULL;
				end
			end
			ACT_DELMIN: begin
				if (cnt_q == '0) begin
					err_code = ST_EMPTY;
				end
			end
			ACT_DELID, ACT_CHKEY: begin
				if (!member_hit) begin
					err_code = ST_NOTMEM;
				end
			end
			default: err_code = ST_OK;
		endcase
	end

	assign cnt_m1    = cnt_q - 1'b1;
	assign last_addr = POS_W'(cnt_m1);
	assign parent    = (p_q - 1'b1) >> 1;
	assign l_ext     = {p_q, 1'b1};
	assign r_ext     = l_ext + 1'b1;
	assign cnt_ext   = CMP_W'(cnt_q);
	assign l_ge      = (l_ext >= cnt_ext);
	assign r_ok      = (r_ext < cnt_ext);

	always_comb begin
		addr_a = '0;
		if (cmd.rd_root) begin
			addr_a = '0;
		end else if (cmd.rd_last) begin
			addr_a = last_addr;
		end else if (cmd.up_rd) begin
			addr_a = parent;
		end else if (cmd.dn_rd) begin
			addr_a = l_ext[POS_W-1:0];
		end
	end
	assign addr_b = r_ext[POS_W-1:0];

	assign pick_r   = r_ok_q && (rb_key < ra_key);
	assign best_id  = pick_r ? rb_id : ra_id;
	assign best_key = pick_r ? rb_key : ra_key;
	assign best_idx = pick_r ? r_ext[POS_W-1:0] : l_ext[POS_W-1:0];

	assign stat.err      = (err_code != ST_OK);
	assign stat.act      = act_q;
	assign stat.cnt_one  = (cnt_q == CNT_W'(1));
	assign stat.last_hit = (rp == last_addr);
	assign stat.p_zero   = (p_q == '0);
	assign stat.l_ge     = l_ge;
	assign stat.up_less  = (e_key_q < ra_key);
	assign stat.dn_less  = (best_key < e_key_q);

	always_comb begin
		slot_we    = cmd.up_swap || cmd.dn_swap || cmd.place;
		slot_waddr = p_q;
		slot_wid   = e_id_q;
		slot_wkey  = e_key_q;
		if (cmd.up_swap) begin
			slot_wid  = ra_id;
			slot_wkey = ra_key;
		end else if (cmd.dn_swap) begin
			slot_wid  = best_id;
			slot_wkey = best_key;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_id_mem[slot_waddr]  <= slot_wid;
			slot_key_mem[slot_waddr] <= slot_wkey;
		end
		ra_id  <= slot_id_mem[addr_a];
		ra_key <= slot_key_mem[addr_a];
		rb_id  <= slot_id_mem[addr_b];
		rb_key <= slot_key_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			pos_mem[IDX_W'(slot_wid)] <= slot_waddr;
		end
		rp <= pos_mem[id_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			member_q <= '0;
		end else begin
			if (cmd.start_clr) begin
				cnt_q    <= '0;
				member_q <= '0;
			end else begin
				if (cmd.start_ins) begin
					cnt_q            <= cnt_q + 1'b1;
					member_q[id_idx] <= 1'b1;
				end
				if (cmd.take_min) begin
					cnt_q                     <= cnt_m1;
					member_q[IDX_W'(ra_id)]   <= 1'b0;
				end
				if (cmd.take_pos && act_q == ACT_DELID) begin
					cnt_q            <= cnt_m1;
					member_q[id_idx] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			act_q <= action;
			id_q  <= elem_id;
			key_q <= KEY_WIDTH'(key);
		end
		if (cmd.decide) begin
			st_q   <= err_code;
			oid_q  <= '0;
			okey_q <= '0;
		end
		if (cmd.take_min) begin
			oid_q  <= ra_id;
			okey_q <= ra_key;
			p_q    <= '0;
		end
		if (cmd.start_ins) begin
			p_q     <= POS_W'(cnt_q);
			e_id_q  <= id_q;
			e_key_q <= key_q;
		end
		if (cmd.take_pos) begin
			p_q     <= rp;
			e_id_q  <= id_q;
			e_key_q <= key_q;
		end
		if (cmd.take_last) begin
			e_id_q  <= ra_id;
			e_key_q <= ra_key;
		end
		if (cmd.up_swap) begin
			p_q <= parent;
		end
		if (cmd.dn_rd) begin
			r_ok_q <= r_ok;
		end
		if (cmd.dn_swap) begin
			p_q <= best_idx;
		end
		if (cmd.load_res) begin
			res_valid_q <= (cnt_q != '0);
			res_id_q    <= (cnt_q != '0) ? ra_id : '0;
			res_key_q   <= (cnt_q != '0) ? ra_key : '0;
		end
		if (cmd.load_out) begin
			status_q    <= st_q;
			out_id_q    <= oid_q;
			out_key_q   <= KEYF_W'(okey_q);
			min_valid_q <= res_valid_q;
			min_id_q    <= res_id_q;
			min_key_q   <= KEYF_W'(res_key_q);
			count_q     <= cnt_q;
		end
	end

	assign status    = status_q;
	assign out_id    = out_id_q;
	assign out_key   = out_key_q;
	assign min_valid = min_valid_q;
	assign min_id    = min_id_q;
	assign min_key   = min_key_q;
	assign count     = count_q;

endmodule

@@ bench/indexed_min_heap_queue_test.sv @@
module indexed_min_heap_queue_test;
	import imq_pkg::*;

	localparam int CAP = 256;
	localparam int CNT_W = 9;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [ACT_W-1:0] action;
	logic [ID_W-1:0] elem_id;
	logic [KEYF_W-1:0] key;
	logic [ST_W-1:0] status;
	logic [ID_W-1:0] out_id, min_id;
	logic [KEYF_W-1:0] out_key, min_key;
	logic min_valid;
	logic [CNT_W-1:0] count;

	indexed_min_heap_queue DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .elem_id(elem_id), .key(key),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_id(out_id), .out_key(out_key),
		.min_valid(min_valid), .min_id(min_id), .min_key(min_key), .count(count)
	);

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [ID_W-1:0] out_id;
		logic [KEYF_W-1:0] out_key;
		logic min_valid;
		logic [ID_W-1:0] min_id;
		logic [KEYF_W-1:0] min_key;
		logic [CNT_W-1:0] count;
	} heap_reply_t;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [ID_W-1:0] id;
		logic [KEYF_W-1:0] k;
		bit has_reply;
		heap_reply_t reply;
	} stim_row_t;

	logic [ID_W-1:0] hp_id [CAP];
	logic [KEYF_W-1:0] hp_key [CAP];
	logic [ID_W-1:0] hp_pos [256];
	bit hp_mem [256];
	int hp_n;

	heap_reply_t replies_due [$];
	int errors = 0;
	int n_sent = 0, n_seen = 0;
	int send_idle = 31, recv_idle = 51;
	int st_hist [8];

	function automatic void hp_place(int p, logic [ID_W-1:0] i, logic [KEYF_W-1:0] k);
		hp_id[p] = i;
		hp_key[p] = k;
		hp_pos[i] = ID_W'(p);
	endfunction

	function automatic void hp_swap(int a, int b);
		logic [ID_W-1:0] ia;
		logic [KEYF_W-1:0] ka;
		ia = hp_id[a];
		ka = hp_key[a];
		hp_place(a, hp_id[b], hp_key[b]);
		hp_place(b, ia, ka);
	endfunction

	function automatic void hp_up(int p);
		while (p != 0 && hp_key[p] < hp_key[(p - 1) / 2]) begin
			hp_swap(p, (p - 1) / 2);
			p = (p - 1) / 2;
		end
	endfunction

	function automatic void hp_down(int p);
		int l, b;
		forever begin
			l = 2 * p + 1;
			if (l >= hp_n) break;
			b = l;
			if (l + 1 < hp_n && hp_key[l + 1] < hp_key[l]) b = l + 1;
			if (!(hp_key[b] < hp_key[p])) break;
			hp_swap(b, p);
			p = b;
		end
	endfunction

	function automatic void hp_remove(int p);
		logic [ID_W-1:0] moved;
		hp_n--;
		if (p == hp_n) return;
		moved = hp_id[hp_n];
		hp_place(p, moved, hp_key[hp_n]);
		hp_up(p);
		hp_down(hp_pos[moved]);
	endfunction

	function automatic heap_reply_t heap_apply(logic [ACT_W-1:0] a, logic [ID_W-1:0] i,
			logic [KEYF_W-1:0] k);
		heap_reply_t r;
		r = '0;
		r.status = ST_OK;
		case (a)
			ACT_INS: begin
				if (hp_mem[i]) r.status = ST_ALREADY;
				else if (hp_n >= CAP) r.status = ST_FULL;
				else begin
					hp_place(hp_n, i, k);
					hp_mem[i] = 1;
					hp_n++;
					hp_up(hp_n - 1);
				end
			end
			ACT_DELMIN: begin
				if (hp_n == 0) r.status = ST_EMPTY;
				else begin
					r.out_id = hp_id[0];
					r.out_key = hp_key[0];
					hp_mem[hp_id[0]] = 0;
					hp_remove(0);
				end
			end
			ACT_DELID: begin
				if (!hp_mem[i]) r.status = ST_NOTMEM;
				else begin
					hp_mem[i] = 0;
					hp_remove(hp_pos[i]);
				end
			end
			ACT_CHKEY: begin
				if (!hp_mem[i]) r.status = ST_NOTMEM;
				else begin
					hp_key[hp_pos[i]] = k;
					hp_up(hp_pos[i]);
					hp_down(hp_pos[i]);
				end
			end
			ACT_CLR: begin
				hp_n = 0;
				foreach (hp_mem[j]) hp_mem[j] = 0;
			end
			default: ;
		endcase
		r.count = CNT_W'(hp_n);
		if (hp_n != 0) begin
			r.min_valid = 1;
			r.min_id = hp_id[0];
			r.min_key = hp_key[0];
		end
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		heap_reply_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, out_id, out_key, min_valid, min_id, min_key, count};
			n_seen++;
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t unexpected transfer %h", $time, got);
			end else begin
				want = replies_due.pop_front();
				st_hist[got.status]++;
				if (got.status !== want.status)
					$display("%0t status exp %0d got %0d", $time, want.status, got.status);
				if (got.out_id !== want.out_id)
					$display("%0t out_id exp %0d got %0d", $time, want.out_id, got.out_id);
				if (got.out_key !== want.out_key)
					$display("%0t out_key exp %h got %h", $time, want.out_key, got.out_key);
				if (got.min_valid !== want.min_valid)
					$display("%0t min_valid exp %0d got %0d", $time, want.min_valid,
						got.min_valid);
				if (got.min_id !== want.min_id)
					$display("%0t min_id exp %0d got %0d", $time, want.min_id, got.min_id);
				if (got.min_key !== want.min_key)
					$display("%0t min_key exp %h got %h", $time, want.min_key, got.min_key);
				if (got.count !== want.count)
					$display("%0t count exp %0d got %0d", $time, want.count, got.count);
				if (got !== want) errors++;
			end
		end
	end

	task automatic send_item(logic [ACT_W-1:0] a, logic [ID_W-1:0] i, logic [KEYF_W-1:0] k,
			bit has_reply, heap_reply_t typed);
		heap_reply_t r;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		action <= a;
		elem_id <= i;
		key <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = heap_apply(a, i, k);
		if (has_reply && r !== typed) begin
			errors++;
			$display("%0t table row exp %h predictor %h", $time, typed, r);
		end
		replies_due.push_back(r);
		n_sent++;
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		in_valid <= 0;
		while (replies_due.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	function automatic logic [ID_W-1:0] member_id();
		int p;
		if (hp_n == 0) return ID_W'($urandom);
		p = $urandom_range(hp_n - 1);
		return hp_id[p];
	endfunction

	function automatic logic [KEYF_W-1:0] rand_key();
		case ($urandom_range(3))
			0: return $urandom_range(15);
			1: return 32'hFFFFFFFF - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	stim_row_t rows [$];
	heap_reply_t none = '0;

	function automatic heap_reply_t mk(logic [ST_W-1:0] s, logic [ID_W-1:0] oi,
			logic [KEYF_W-1:0] ok, logic mv, logic [ID_W-1:0] mi, logic [KEYF_W-1:0] mk_,
			logic [CNT_W-1:0] c);
		heap_reply_t r;
		r = '{s, oi, ok, mv, mi, mk_, c};
		return r;
	endfunction

	initial begin
		logic [ACT_W-1:0] a;
		logic [ID_W-1:0] i;
		int u;
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		action = ACT_INS;
		elem_id = 0;
		key = 0;
		hp_n = 0;
		foreach (hp_mem[j]) hp_mem[j] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		rows.push_back('{ACT_DELMIN, 8'd0, 32'd0, 1, mk(ST_EMPTY, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{ACT_DELID, 8'd5, 32'd0, 1, mk(ST_NOTMEM, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{ACT_CHKEY, 8'd255, 32'd1, 1, mk(ST_NOTMEM, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{ACT_INS, 8'd255, 32'hFFFFFFFF, 1,
			mk(ST_OK, 0, 0, 1, 255, 32'hFFFFFFFF, 1)});
		rows.push_back('{ACT_INS, 8'd0, 32'd0, 1, mk(ST_OK, 0, 0, 1, 0, 0, 2)});
		rows.push_back('{ACT_INS, 8'd0, 32'd7, 1, mk(ST_ALREADY, 0, 0, 1, 0, 0, 2)});
		rows.push_back('{ACT_INS, 8'd9, 32'd0, 0, none});
		rows.push_back('{ACT_INS, 8'd10, 32'd50, 0, none});
		rows.push_back('{ACT_INS, 8'd11, 32'd20, 0, none});
		rows.push_back('{ACT_CHKEY, 8'd255, 32'd1, 0, none});
		rows.push_back('{ACT_CHKEY, 8'd10, 32'hFFFFFFFF, 0, none});
		rows.push_back('{ACT_DELID, 8'd11, 32'd0, 0, none});
		rows.push_back('{ACT_DELMIN, 8'd0, 32'd0, 1, mk(ST_OK, 0, 0, 1, 9, 0, 3)});
		rows.push_back('{ACT_DELMIN, 8'd0, 32'd0, 0, none});
		rows.push_back('{3'd5, 8'd3, 32'd3, 0, none});
		rows.push_back('{3'd7, 8'd170, 32'h55555555, 0, none});
		rows.push_back('{ACT_CLR, 8'd0, 32'd0, 1, mk(ST_OK, 0, 0, 0, 0, 0, 0)});
		rows.push_back('{ACT_DELID, 8'd0, 32'd0, 1, mk(ST_NOTMEM, 0, 0, 0, 0, 0, 0)});
		foreach (rows[r]) send_item(rows[r].act, rows[r].id, rows[r].k,
			rows[r].has_reply, rows[r].reply);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 31 : (ph == 1) ? 51 : 0;
			recv_idle = (ph == 0) ? 51 : (ph == 1) ? 31 : 0;
			if (ph == 2) begin
				// fill to capacity, clear and refill, then re-insert ids already held
				for (int j = 0; j < CAP; j++)
					send_item(ACT_INS, ID_W'(j), rand_key(), 0, none);
				send_item(ACT_INS, 8'd3, 32'd1, 0, none);
				send_item(ACT_CLR, 0, 0, 0, none);
				send_item(ACT_INS, 8'd3, 32'd1, 0, none);
				for (int j = 0; j < CAP; j++)
					if (!hp_mem[j]) send_item(ACT_INS, ID_W'(j), rand_key(), 0, none);
				send_item(ACT_INS, 8'd77, 32'd0, 0, none);
				send_item(ACT_INS, 8'd77, 32'd0, 0, none);
			end
			for (int n = 0; n < 140; n++) begin
				u = $urandom_range(99);
				if (u < 38) begin
					a = ACT_INS;
					i = (u < 33) ? ID_W'($urandom) : member_id();
				end else if (u < 58) a = ACT_DELMIN;
				else if (u < 72) begin
					a = ACT_DELID;
					i = (u < 68) ? member_id() : ID_W'($urandom);
				end else if (u < 92) begin
					a = ACT_CHKEY;
					i = (u < 88) ? member_id() : ID_W'($urandom);
				end else if (u < 95) a = ACT_CLR;
				else a = ACT_W'($urandom_range(7));
				if (a != ACT_INS && a != ACT_DELID && a != ACT_CHKEY) i = ID_W'($urandom);
				send_item(a, i, rand_key(), 0, none);
			end
			// hold the sender until every reply is back
			drain();
		end

		drain();
		repeat (60) @(posedge clk);
		$display("tb: %0d items sent, %0d replies checked over three idle mixes", n_sent, n_seen);
		$display("tb: status ok %0d full %0d empty %0d notmem %0d already %0d",
			st_hist[ST_OK], st_hist[ST_FULL], st_hist[ST_EMPTY], st_hist[ST_NOTMEM],
			st_hist[ST_ALREADY]);
		if (errors == 0 && replies_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/imq_pkg.sv
rtl/imq_ctrl.sv
rtl/imq_dpath.sv
rtl/indexed_min_heap_queue.sv
bench/indexed_min_heap_queue_test.sv
